[sv/hkf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_pkg
// Shared types and constants of the two-state heading Kalman filter.
// ----------------------------------------------------------------------------
package hkf_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 2'd3;

  localparam logic [20:0] TIME_STEP_RST = 21'd6554;
  localparam logic [30:0] PROC_NOISE_RST = 31'd655;
  localparam logic [30:0] MEAS_NOISE_RST = 31'd327680;
  localparam logic [30:0] INIT_COV_RST = 31'd65536000;

  // Datapath micro-operations.
  localparam logic [4:0] OP_INIT = 5'd0;   // optional new-track load
  localparam logic [4:0] OP_PH = 5'd1;     // heading += dt*rate
  localparam logic [4:0] OP_PA = 5'd2;     // a = P00 + dt*P01
  localparam logic [4:0] OP_PB = 5'd3;     // b = P01 + dt*P11
  localparam logic [4:0] OP_P00 = 5'd4;    // P00 = a + dt*b + q; P01 = b
  localparam logic [4:0] OP_P11 = 5'd5;    // P11 += q; y; S
  localparam logic [4:0] OP_DIV0 = 5'd6;   // start K0 division
  localparam logic [4:0] OP_DIV1 = 5'd7;   // start K1 division
  localparam logic [4:0] OP_UH = 5'd8;     // heading += K0*y
  localparam logic [4:0] OP_UR = 5'd9;     // rate += K1*y
  localparam logic [4:0] OP_U00 = 5'd10;   // P00 -= K0*P00
  localparam logic [4:0] OP_U01 = 5'd11;   // P01 -= K0*P01
  localparam logic [4:0] OP_U11 = 5'd12;   // P11 -= K1*P01
  localparam logic [4:0] OP_NONE = 5'd13;

  typedef struct packed {
    logic       load;   // capture input item
    logic       exec;   // run op this cycle
    logic [4:0] op;
  } hkf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } hkf_stat_t;

endpackage
`default_nettype wire

[sv/hkf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_datapath
// Filter state, one shared multiplier with saturating accumulate, and a
// serial restoring divider for the gains.
// ----------------------------------------------------------------------------
module hkf_datapath
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkf_cmd_t          cmd,
  output hkf_stat_t              stat,
  input  wire logic [20:0]       time_step,
  input  wire logic [30:0]       process_noise,
  input  wire logic [30:0]       measure_noise,
  input  wire logic [30:0]       initial_cov,
  input  wire logic signed [31:0] heading_meas,
  input  wire logic              new_track,
  output logic signed [31:0]     heading_est,
  output logic signed [31:0]     rate_est,
  output logic                   overflow
);

  localparam int unsigned NUM_W = 32 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic signed [31:0] est_h, est_r, p00, p01, p11;
  logic signed [31:0] z, a_t, b_t, y, s, k0, k1;
  logic               nt, sat;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

  // Shared multiplier operand selection.
  logic signed [31:0] ma, mb, addend;
  logic signed [31:0] dt_s, q_s, r_s;
  assign dt_s = $signed({11'd0, time_step});
  assign q_s = $signed({1'b0, process_noise});
  assign r_s = $signed({1'b0, measure_noise});

  always_comb begin
    ma = dt_s;
    mb = est_r;
    addend = est_h;
    case (cmd.op)
      OP_PH: begin ma = dt_s; mb = est_r; addend = est_h; end
      OP_PA: begin ma = dt_s; mb = p01; addend = p00; end
      OP_PB: begin ma = dt_s; mb = p11; addend = p01; end
      OP_P00: begin ma = dt_s; mb = b_t; addend = a_t; end
      OP_UH: begin ma = k0; mb = y; addend = est_h; end
      OP_UR: begin ma = k1; mb = y; addend = est_r; end
      OP_U00: begin ma = k0; mb = p00; addend = p00; end
      OP_U01: begin ma = k0; mb = p01; addend = p01; end
      OP_U11: begin ma = k1; mb = p01; addend = p11; end
      default: ;
    endcase
  end

  logic signed [63:0] prod;
  logic signed [65:0] m_w;
  logic               m_hit;
  logic signed [31:0] m_q;
  assign prod = ma * mb + (64'sd1 <<< (FRAC_BITS - 1));
  assign m_w = 66'(prod >>> FRAC_BITS);
  assign m_q = sat32(m_w);
  assign m_hit = ovf32(m_w);

  // Subtracting ops use the negated product.
  logic               sub_op;
  assign sub_op = (cmd.op == OP_U00) || (cmd.op == OP_U01) || (cmd.op == OP_U11);
  logic signed [32:0] term;
  assign term = sub_op ? -33'(m_q) : 33'(m_q);
  logic signed [65:0] acc_w;
  logic signed [31:0] acc;
  logic               acc_hit;
  assign acc_w = 66'(addend) + 66'(term);
  assign acc = sat32(acc_w);
  assign acc_hit = ovf32(acc_w);

  // P00 needs one more saturating add of q.
  logic signed [65:0] p00q_w;
  logic signed [31:0] p00q;
  logic               p00q_hit;
  assign p00q_w = 66'(acc) + 66'(q_s);
  assign p00q = sat32(p00q_w);
  assign p00q_hit = ovf32(p00q_w);

  logic signed [65:0] p11q_w, y_w, s_w;
  logic signed [31:0] p11q, yv, sv0;
  logic               p11q_hit, y_hit, s_hit;
  assign p11q_w = 66'(p11) + 66'(q_s);
  assign y_w = 66'(z) - 66'(est_h);
  assign s_w = 66'(p00) + 66'(r_s);
  assign p11q = sat32(p11q_w);
  assign p11q_hit = ovf32(p11q_w);
  assign yv = sat32(y_w);
  assign y_hit = ovf32(y_w);
  assign sv0 = sat32(s_w);
  assign s_hit = ovf32(s_w);

  // Serial divider: |num| * 2^FRAC_BITS / |s|, one quotient bit a cycle.
  logic [NUM_W-1:0] dnum;
  logic [31:0]      drem;
  logic [31:0]      dden;
  logic [CNT_W-1:0] dcnt;
  logic             dneg, dsel;
  logic             dbusy;
  logic [32:0]      trial;
  assign trial = {drem, dnum[NUM_W-1]} - {1'b0, dden};
  assign stat.div_busy = dbusy;

  logic [NUM_W:0]     qmag;
  logic signed [NUM_W+1:0] qsig;
  logic signed [65:0] q_w;
  logic signed [31:0] qsat;
  logic               q_hit;
  assign qmag = {1'b0, dnum};
  assign qsig = dneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign q_w = 66'(qsig);
  assign qsat = sat32(q_w);
  assign q_hit = ovf32(q_w);

  logic signed [31:0] dsrc;
  logic [31:0]        dsrc_mag;
  assign dsrc = (cmd.op == OP_DIV0) ? p00 : p01;
  assign dsrc_mag = dsrc[31] ? 32'(-dsrc) : dsrc;

  // Saturation seen by the operation that runs this cycle. A finished
  // quotient is stored on the op that follows its division.
  logic sat_set;
  always_comb begin
    sat_set = 1'b0;
    if (cmd.exec) begin
      unique case (cmd.op) inside
        OP_PH, OP_PA, OP_PB, OP_UR, OP_U00, OP_U01, OP_U11: sat_set = m_hit | acc_hit;
        OP_P00: sat_set = m_hit | acc_hit | p00q_hit;
        OP_P11: sat_set = p11q_hit | y_hit | s_hit | (sv0 <= 0);
        OP_DIV1: sat_set = q_hit;
        OP_UH: sat_set = m_hit | acc_hit | q_hit;
        default: sat_set = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_h <= '0;
      est_r <= '0;
      p00 <= $signed({1'b0, INIT_COV_RST});
      p01 <= '0;
      p11 <= $signed({1'b0, INIT_COV_RST});
      dbusy <= 1'b0;
      sat <= 1'b0;
    end else begin
      if (cmd.load) begin
        z <= heading_meas;
        nt <= new_track;
        sat <= 1'b0;
      end else if (sat_set) begin
        sat <= 1'b1;
      end
      if (dbusy) begin
        if (!trial[32]) begin
          drem <= trial[31:0];
          dnum <= {dnum[NUM_W-2:0], 1'b1};
        end else begin
          drem <= {drem[30:0], dnum[NUM_W-1]};
          dnum <= {dnum[NUM_W-2:0], 1'b0};
        end
        dcnt <= dcnt - CNT_W'(1);
        if (dcnt == CNT_W'(1)) dbusy <= 1'b0;
      end else if (cmd.exec && (cmd.op == OP_DIV1 || cmd.op == OP_UH)) begin
        // Store the finished quotient of the previous division.
        if (dsel) k1 <= qsat; else k0 <= qsat;
      end
      if (cmd.exec) begin
        unique case (cmd.op) inside
          OP_INIT: if (nt) begin
            est_h <= z;
            est_r <= '0;
            p00 <= $signed({1'b0, initial_cov});
            p01 <= '0;
            p11 <= $signed({1'b0, initial_cov});
          end
          OP_PH: est_h <= acc;
          OP_PA: a_t <= acc;
          OP_PB: b_t <= acc;
          OP_P00: begin
            p00 <= p00q;
            p01 <= b_t;
          end
          OP_P11: begin
            p11 <= p11q;
            y <= yv;
            if (sv0 <= 0) s <= 32'sd1; else s <= sv0;
          end
          OP_DIV0, OP_DIV1: begin
            dnum <= NUM_W'({dsrc_mag, FRAC_BITS'(0)});
            drem <= '0;
            dden <= s;
            dneg <= dsrc[31];
            dsel <= (cmd.op == OP_DIV1);
            dcnt <= CNT_W'(NUM_W);
            dbusy <= 1'b1;
          end
          OP_UH: est_h <= acc;
          OP_UR: est_r <= acc;
          OP_U00: p00 <= acc;
          OP_U01: p01 <= acc;
          OP_U11: p11 <= acc;
          default: ;
        endcase
      end
    end
  end

  // K1*P01 must use the pre-update P01, so the controller orders U11
  // ahead of U01.
  assign heading_est = est_h;
  assign rate_est = est_r;
  assign overflow = sat;

endmodule
`default_nettype wire

[sv/hkf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_ctrl
// Sequencer that steps the datapath through predict and update.
// ----------------------------------------------------------------------------
module hkf_ctrl
  import hkf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output hkf_cmd_t  cmd,
  input  wire hkf_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0] state;
  logic [4:0] op;

  // Operation after the current one; U11 precedes U01 to keep old P01.
  logic [4:0] op_next;
  always_comb begin
    unique case (op)
      OP_INIT: op_next = OP_PH;
      OP_PH: op_next = OP_PA;
      OP_PA: op_next = OP_PB;
      OP_PB: op_next = OP_P00;
      OP_P00: op_next = OP_P11;
      OP_P11: op_next = OP_DIV0;
      OP_DIV0: op_next = OP_DIV1;
      OP_DIV1: op_next = OP_UH;
      OP_UH: op_next = OP_UR;
      OP_UR: op_next = OP_U00;
      OP_U00: op_next = OP_U11;
      OP_U11: op_next = OP_U01;
      default: op_next = OP_NONE;
    endcase
  end

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state == ST_RUN) || (out_valid && out_stall);

  always_comb begin
    cmd.load = accept;
    cmd.exec = (state == ST_RUN) && !stat.div_busy;
    cmd.op = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state) inside
        ST_IDLE, ST_OUT: if (accept) begin
          state <= ST_RUN;
          op <= OP_INIT;
        end else state <= ST_IDLE;
        ST_RUN: if (!stat.div_busy) begin
          if (op == OP_U01) begin
            state <= ST_OUT;
            out_valid <= 1'b1;
            op <= OP_NONE;
          end else op <= op_next;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/heading_kalman_filter_2state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heading_kalman_filter_2state
// Two-state constant-velocity Kalman filter on Q16.16 heading samples.
// ----------------------------------------------------------------------------
// Each measurement runs 13 sequencer steps plus two serial divisions of
// 32+FRAC_BITS quotient bits each, the gain divider giving one bit a cycle.
// The next item can be taken at the edge on which the result transfers.
// One item is in work at a time, and a result held by the receiver stalls
// the input until it transfers.
module heading_kalman_filter_2state
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [31:0] heading_meas,
  input  wire logic              new_track,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     heading_est,
  output logic signed [31:0]     rate_est,
  output logic                   overflow,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data
);

  logic [20:0] time_step;
  logic [30:0] process_noise, measure_noise, initial_cov;
  hkf_cmd_t    cmd;
  hkf_stat_t   stat;
  logic signed [31:0] h_w, r_w;
  logic        ov_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      process_noise <= PROC_NOISE_RST;
      measure_noise <= MEAS_NOISE_RST;
      initial_cov <= INIT_COV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data[20:0];
        REG_PROC_NOISE: process_noise <= cfg_data[30:0];
        REG_MEAS_NOISE: measure_noise <= cfg_data[30:0];
        REG_INIT_COV: initial_cov <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  hkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  hkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .time_step(time_step), .process_noise(process_noise),
    .measure_noise(measure_noise), .initial_cov(initial_cov),
    .heading_meas(heading_meas), .new_track(new_track),
    .heading_est(h_w), .rate_est(r_w), .overflow(ov_w)
  );

  assign heading_est = h_w;
  assign rate_est = r_w;
  assign overflow = ov_w;

`ifndef SYNTH
  // No new item is taken while a result is stalled at the output.
  a_no_take_while_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("item accepted while result held");
  // A held result keeps its values.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(heading_est) && $stable(rate_est))
    else $error("held result changed");
  // The input stays stalled while a gain division is in progress.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> in_stall)
    else $error("input open during division");
`endif

endmodule
`default_nettype wire
